// ===== hdl/gei_pkg.sv =====
// gei_pkg: shared types and codes of the gpio expander with edge interrupts
// depends on nothing; imported by every module of the block
package gei_pkg;

    // operation codes carried in the func field
    localparam logic [3:0] FUNC_DIR_IN   = 4'd0;
    localparam logic [3:0] FUNC_DIR_OUT  = 4'd1;
    localparam logic [3:0] FUNC_SET      = 4'd2;
    localparam logic [3:0] FUNC_GET      = 4'd3;
    localparam logic [3:0] FUNC_SET_TYPE = 4'd4;
    localparam logic [3:0] FUNC_MASK     = 4'd5;
    localparam logic [3:0] FUNC_UNMASK   = 4'd6;
    localparam logic [3:0] FUNC_SYNC     = 4'd7;
    localparam logic [3:0] FUNC_SAMPLE   = 4'd8;
    localparam logic [3:0] FUNC_LATCH    = 4'd9;

    // status codes of a result
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_EDGE = 2'd1;
    localparam logic [1:0] STATUS_FAIL    = 2'd2;

    localparam int PinWidth   = 4;
    localparam int PortWidth  = 16;
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    typedef enum logic [3:0] {
        OP_DIR_IN,
        OP_DIR_OUT,
        OP_SET,
        OP_GET,
        OP_SET_TYPE,
        OP_MASK,
        OP_UNMASK,
        OP_SYNC,
        OP_SAMPLE,
        OP_LATCH,
        OP_NOP
    } t_op;

    // classified item as it travels from front to back
    typedef struct packed {
        t_op                   op;
        logic [PortWidth-1:0]  pin_mask;
        logic                  level;
        logic [1:0]            edge_type;
        logic [PortWidth-1:0]  levels;
        logic                  ok;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [1:0]            status;
        logic                  read_bit;
        logic                  irq_valid;
        logic [PinWidth-1:0]   irq_pin;
        logic                  last;
        logic [PortWidth-1:0]  output_state;
        logic [PortWidth-1:0]  direction_state;
    } t_res;

    // handshake between queue and its neighbors
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

endpackage

// ===== hdl/gei_if.sv =====
// gei_if: valid/ready channel interfaces of the gpio expander
// no dependencies; used by the top level, front and back
interface gei_cfg_if;
    logic valid;
    logic ready;
    logic access_enabled;

    modport source (output valid, output access_enabled, input ready);
    modport sink   (input valid, input access_enabled, output ready);
endinterface

interface gei_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  func;
    logic [3:0]  pin;
    logic        level;
    logic [1:0]  edge_type;
    logic [15:0] pin_levels;
    logic        bus_fail;

    modport source (output valid, output func, output pin, output level, output edge_type,
                    output pin_levels, output bus_fail, input ready);
    modport sink   (input valid, input func, input pin, input level, input edge_type,
                    input pin_levels, input bus_fail, output ready);
endinterface

interface gei_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        read_bit;
    logic        irq_valid;
    logic [3:0]  irq_pin;
    logic        last;
    logic [15:0] output_state;
    logic [15:0] direction_state;

    modport source (output valid, output status, output read_bit, output irq_valid,
                    output irq_pin, output last, output output_state,
                    output direction_state, input ready);
    modport sink   (input valid, input status, input read_bit, input irq_valid,
                    input irq_pin, input last, input output_state,
                    input direction_state, output ready);
endinterface

// ===== hdl/gpio_expander_edge_irq.sv =====
// an accepted item is written into the queue, then executed from its head into the output register
// throughput: one item per cycle sustained while results are taken; a sample with pending pins
// holds the back end while it loads the pins, then gives one result per pin, lowest pin first;
// results wait in an output register so the front keeps accepting into the two-entry queue
// reset: synchronous, active low; all pins inputs, outputs high, triggers, mask and snapshot
// clear, access enabled; no clearing pass
module gpio_expander_edge_irq #(
    parameter int PIN_COUNT = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gei_cfg_if.sink   i_cfg,
    gei_in_if.sink    i_in,
    gei_out_if.source o_out
);
    import gei_pkg::*;

    // access enable register; the user must write it only while the block is idle, the block does not enforce this
    logic r_access_enabled;

    // front to queue
    logic      push;
    t_cmd      front_cmd;

    // queue to back
    t_q_status q_status;
    t_cmd      head_cmd;
    logic      pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_access_enabled <= 1'b1;
        end else if (i_cfg.valid) begin
            r_access_enabled <= i_cfg.access_enabled;
        end
    end

    // front: decodes func, builds the pin mask, samples the access state
    gei_front #(
        .PIN_COUNT (PIN_COUNT)
    ) u_front (
        .i_in             (i_in),
        .i_access_enabled (r_access_enabled),
        .i_q_status       (q_status),
        .o_push           (push),
        .o_cmd            (front_cmd)
    );

    // queue decouples acceptance from execution and output stalls
    gei_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_status (q_status),
        .o_cmd    (head_cmd)
    );

    // back: owns the pin registers and walks pending interrupt pins
    gei_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_cmd      (head_cmd),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

// ===== hdl/gei_front.sv =====
// gei_front: accepts items and classifies them into queue commands
// depends on gei_pkg and gei_in_if
module gei_front #(
    parameter int PIN_COUNT = 16
) (
    gei_in_if.sink           i_in,
    input  logic             i_access_enabled,
    input  gei_pkg::t_q_status i_q_status,
    output logic             o_push,
    output gei_pkg::t_cmd    o_cmd
);
    import gei_pkg::*;

    localparam logic [PortWidth-1:0] PinMask =
        PortWidth'((17'd1 << PIN_COUNT) - 17'd1);

    logic pin_ok;

    assign pin_ok     = {1'b0, i_in.pin} < (PinWidth+1)'(PIN_COUNT);
    assign i_in.ready = !i_q_status.full;
    assign o_push     = i_in.valid && !i_q_status.full;

    always_comb begin
        o_cmd.pin_mask  = PortWidth'(1) << i_in.pin;
        o_cmd.level     = i_in.level;
        o_cmd.edge_type = i_in.edge_type;
        o_cmd.levels    = i_in.pin_levels & PinMask;
        o_cmd.ok        = i_access_enabled && !i_in.bus_fail;
        unique case (i_in.func)
            FUNC_DIR_IN:   o_cmd.op = OP_DIR_IN;
            FUNC_DIR_OUT:  o_cmd.op = OP_DIR_OUT;
            FUNC_SET:      o_cmd.op = OP_SET;
            FUNC_GET:      o_cmd.op = OP_GET;
            FUNC_SET_TYPE: o_cmd.op = OP_SET_TYPE;
            FUNC_MASK:     o_cmd.op = OP_MASK;
            FUNC_UNMASK:   o_cmd.op = OP_UNMASK;
            FUNC_SYNC:     o_cmd.op = OP_SYNC;
            FUNC_SAMPLE:   o_cmd.op = OP_SAMPLE;
            FUNC_LATCH:    o_cmd.op = OP_LATCH;
            default:       o_cmd.op = OP_NOP;
        endcase
        // pin operations on a pin that does not exist do nothing
        if (i_in.func <= FUNC_UNMASK && !pin_ok) begin
            o_cmd.op = OP_NOP;
        end
    end

endmodule

// ===== hdl/gei_fifo.sv =====
// gei_fifo: short command queue between front and back
// depends on gei_pkg
module gei_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gei_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output gei_pkg::t_q_status o_status,
    output gei_pkg::t_cmd      o_cmd
);
    import gei_pkg::*;

    t_cmd                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr;
    logic [QueuePtrW:0]   r_count;

    assign o_status.full  = r_count == (QueuePtrW+1)'(QueueDepth);
    assign o_status.valid = r_count != '0;
    assign o_cmd          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/gei_back.sv =====
// gei_back: executes queued commands on the pin registers and drives results
// depends on gei_pkg and gei_out_if
module gei_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gei_pkg::t_q_status i_q_status,
    input  gei_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    gei_out_if.source          o_out
);
    import gei_pkg::*;

    logic [PortWidth-1:0] r_dir, n_dir;
    logic [PortWidth-1:0] r_outb, n_outb;
    logic [PortWidth-1:0] r_en, n_en;
    logic [PortWidth-1:0] r_fall, n_fall;
    logic [PortWidth-1:0] r_rise, n_rise;
    logic [PortWidth-1:0] r_snap, n_snap;
    logic [PortWidth-1:0] r_pend, n_pend;
    logic                 r_out_valid, n_out_valid;
    t_res                 r_res, n_res;

    logic                 out_free;
    logic [PinWidth-1:0]  low_pin;
    logic [PortWidth-1:0] pend_rest;
    logic [PortWidth-1:0] cur, trig, pend, fresh;

    assign out_free  = !r_out_valid || o_out.ready;
    assign pend_rest = r_pend & (r_pend - 1'b1);

    // lowest pending pin
    always_comb begin
        low_pin = '0;
        for (int i = PortWidth - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                low_pin = PinWidth'(i);
            end
        end
    end

    assign cur   = i_cmd.levels & r_dir;
    assign trig  = (cur ^ r_snap) & r_en;
    assign pend  = ((r_snap & r_fall) | (cur & r_rise)) & trig;
    assign fresh = (r_fall | r_rise) & ~r_dir;

    always_comb begin
        n_dir       = r_dir;
        n_outb      = r_outb;
        n_en        = r_en;
        n_fall      = r_fall;
        n_rise      = r_rise;
        n_snap      = r_snap;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !o_out.ready;
        n_res       = r_res;
        o_pop       = 1'b0;

        if (r_pend != '0) begin
            if (out_free) begin
                n_out_valid           = 1'b1;
                n_res.status          = STATUS_OK;
                n_res.read_bit        = 1'b0;
                n_res.irq_valid       = 1'b1;
                n_res.irq_pin         = low_pin;
                n_res.last            = pend_rest == '0;
                n_res.output_state    = r_outb;
                n_res.direction_state = r_dir;
                n_pend                = pend_rest;
            end
        end else if (i_q_status.valid && out_free) begin
            o_pop          = 1'b1;
            n_res.status   = STATUS_OK;
            n_res.read_bit = 1'b0;
            n_res.irq_valid = 1'b0;
            n_res.irq_pin  = '0;
            n_res.last     = 1'b1;
            n_out_valid    = 1'b1;
            unique case (i_cmd.op)
                OP_DIR_IN: begin
                    if (i_cmd.ok) n_dir = r_dir | i_cmd.pin_mask;
                    else          n_res.status = STATUS_FAIL;
                end
                OP_DIR_OUT: begin
                    if (i_cmd.ok) begin
                        n_outb = i_cmd.level ? (r_outb | i_cmd.pin_mask)
                                             : (r_outb & ~i_cmd.pin_mask);
                        n_dir  = r_dir & ~i_cmd.pin_mask;
                    end else begin
                        n_res.status = STATUS_FAIL;
                    end
                end
                OP_SET: begin
                    if (i_cmd.ok) begin
                        n_outb = i_cmd.level ? (r_outb | i_cmd.pin_mask)
                                             : (r_outb & ~i_cmd.pin_mask);
                    end else begin
                        n_res.status = STATUS_FAIL;
                    end
                end
                OP_GET: begin
                    if (i_cmd.ok) n_res.read_bit = |(i_cmd.levels & i_cmd.pin_mask);
                    else          n_res.status = STATUS_FAIL;
                end
                OP_SET_TYPE: begin
                    if (i_cmd.edge_type == 2'b00) begin
                        n_res.status = STATUS_NO_EDGE;
                    end else begin
                        n_fall = i_cmd.edge_type[1] ? (r_fall | i_cmd.pin_mask)
                                                    : (r_fall & ~i_cmd.pin_mask);
                        n_rise = i_cmd.edge_type[0] ? (r_rise | i_cmd.pin_mask)
                                                    : (r_rise & ~i_cmd.pin_mask);
                    end
                end
                OP_MASK:   n_en = r_en & ~i_cmd.pin_mask;
                OP_UNMASK: n_en = r_en | i_cmd.pin_mask;
                OP_SYNC: begin
                    if (fresh != '0) begin
                        if (i_cmd.ok) n_dir = r_dir | fresh;
                        else          n_res.status = STATUS_FAIL;
                    end
                end
                OP_SAMPLE: begin
                    if (!i_cmd.ok) begin
                        n_res.status = STATUS_FAIL;
                    end else if (trig != '0) begin
                        n_snap = cur;
                        if (pend != '0) begin
                            // pending pins go out one per cycle from here on while the output is free
                            n_out_valid = 1'b0;
                            n_pend      = pend;
                        end
                    end
                end
                OP_LATCH: begin
                    if (i_cmd.ok) n_snap = cur;
                    else          n_res.status = STATUS_FAIL;
                end
                default: begin
                end
            endcase
            n_res.output_state    = n_outb;
            n_res.direction_state = n_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir       <= '1;
            r_outb      <= '1;
            r_en        <= '0;
            r_fall      <= '0;
            r_rise      <= '0;
            r_snap      <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_dir       <= n_dir;
            r_outb      <= n_outb;
            r_en        <= n_en;
            r_fall      <= n_fall;
            r_rise      <= n_rise;
            r_snap      <= n_snap;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_res.status;
    assign o_out.read_bit        = r_res.read_bit;
    assign o_out.irq_valid       = r_res.irq_valid;
    assign o_out.irq_pin         = r_res.irq_pin;
    assign o_out.last            = r_res.last;
    assign o_out.output_state    = r_res.output_state;
    assign o_out.direction_state = r_res.direction_state;

endmodule

// ===== hdl/gei_chk.sv =====
// gei_chk: port-level checks of the gpio expander result channel
// depends on gei_pkg; bound to gpio_expander_edge_irq
module gei_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_status,
    input logic        i_read_bit,
    input logic        i_irq_valid,
    input logic [3:0]  i_irq_pin,
    input logic        i_last
);
    import gei_pkg::*;

    // a stalled result keeps its pin
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_irq_pin) && $stable(i_status))
        else $error("result changed while stalled");

    a_irq_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_irq_valid |-> i_status == STATUS_OK && !i_read_bit)
        else $error("interrupt result with bad status");

    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != STATUS_OK |-> i_last && !i_read_bit && !i_irq_valid)
        else $error("refused item gave more than one plain result");

    a_no_irq_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_irq_valid |-> i_irq_pin == '0 && i_last)
        else $error("non-interrupt result with pin or not last");

endmodule

bind gpio_expander_edge_irq gei_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_status    (o_out.status),
    .i_read_bit  (o_out.read_bit),
    .i_irq_valid (o_out.irq_valid),
    .i_irq_pin   (o_out.irq_pin),
    .i_last      (o_out.last)
);

// ===== verif/tb_gpio_expander_edge_irq.sv =====
// tb_gpio_expander_edge_irq: self-checking bench for the 16-pin expander with edge interrupts
// depends on hdl/gei_pkg.sv and hdl/gei_if.sv and the gpio_expander_edge_irq top level
// a cycle-free model of the register cache predicts every result item, checked in order
module tb_gpio_expander_edge_irq;
    timeunit 1ns;
    timeprecision 1ps;

    import gei_pkg::*;

    localparam int PIN_COUNT = 16;
    localparam logic [15:0] PIN_MASK = 16'((32'h1 << PIN_COUNT) - 1);
    // highest code of the func field, no operation behind it
    localparam logic [3:0] FUNC_UNUSED_TOP = 4'd15;
    // generous guard, several times the slowest legal run
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    // one request item as the sender sees it
    typedef struct packed {
        logic [3:0]  func;
        logic [3:0]  pin;
        logic        level;
        logic [1:0]  edge_type;
        logic [15:0] pin_levels;
        logic        bus_fail;
    } t_expander_req;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gei_cfg_if cfg_ch ();
    gei_in_if  in_ch ();
    gei_out_if out_ch ();

    gpio_expander_edge_irq #(
        .PIN_COUNT(PIN_COUNT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch.sink),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // shadow copy of the block's cached registers
    logic        access_en   = 1'b1;
    logic [15:0] dir_bits    = 16'hFFFF;
    logic [15:0] out_bits    = 16'hFFFF;
    logic [15:0] irq_en_bits = 16'h0000;
    logic [15:0] fall_bits   = 16'h0000;
    logic [15:0] rise_bits   = 16'h0000;
    logic [15:0] snap_bits   = 16'h0000;

    // results still owed by the block, oldest first
    t_res expected_results[$];

    // levels on the expander pins as the random sequences move them
    logic [15:0] wire_levels = 16'h0000;

    bit idle_on = 1'b1;
    int err_count    = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int irq_results  = 0;
    int access_writes = 0;

    t_res seen_res;
    t_res want_res;

    // clock, 12 ns period
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout: %0d results still pending", expected_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // one line per mismatch, only the first few are printed
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (err_count < 20)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic void push_result(input logic [1:0] st, input logic rb, input logic iv,
                                        input logic [3:0] ipin, input logic lst);
        t_res r;
        r.status          = st;
        r.read_bit        = rb;
        r.irq_valid       = iv;
        r.irq_pin         = ipin;
        r.last            = lst;
        r.output_state    = out_bits;
        r.direction_state = dir_bits;
        expected_results.push_back(r);
    endfunction

    // expected result items of one accepted request, state updated in place
    function automatic void predict_results(input t_expander_req r);
        logic [15:0] bit_m;
        logic [15:0] lv;
        logic [15:0] cur;
        logic [15:0] old;
        logic [15:0] trig;
        logic [15:0] pend;
        logic [15:0] fresh;
        logic        ok;
        logic [1:0]  st;
        logic        rb;
        int          p;
        lv    = r.pin_levels & PIN_MASK;
        ok    = access_en && !r.bus_fail;
        bit_m = 16'h0001 << r.pin;
        st    = STATUS_OK;
        rb    = 1'b0;
        // pin beyond the pin count on a per-pin operation: nothing happens
        if (r.func <= FUNC_UNMASK && r.pin >= PIN_COUNT) begin
            push_result(STATUS_OK, 1'b0, 1'b0, 4'd0, 1'b1);
            return;
        end
        case (r.func)
            FUNC_DIR_IN: begin
                if (ok) dir_bits |= bit_m;
                else st = STATUS_FAIL;
            end
            FUNC_DIR_OUT: begin
                if (ok) begin
                    out_bits = r.level ? (out_bits | bit_m) : (out_bits & ~bit_m);
                    dir_bits &= ~bit_m;
                end else st = STATUS_FAIL;
            end
            FUNC_SET: begin
                if (ok) out_bits = r.level ? (out_bits | bit_m) : (out_bits & ~bit_m);
                else st = STATUS_FAIL;
            end
            FUNC_GET: begin
                if (ok) rb = |(lv & bit_m);
                else st = STATUS_FAIL;
            end
            FUNC_SET_TYPE: begin
                // software only, access state does not matter
                if (r.edge_type == 2'd0) begin
                    st = STATUS_NO_EDGE;
                end else begin
                    fall_bits = r.edge_type[1] ? (fall_bits | bit_m) : (fall_bits & ~bit_m);
                    rise_bits = r.edge_type[0] ? (rise_bits | bit_m) : (rise_bits & ~bit_m);
                end
            end
            FUNC_MASK:   irq_en_bits &= ~bit_m;
            FUNC_UNMASK: irq_en_bits |= bit_m;
            FUNC_SYNC: begin
                // only triggered pins that are outputs need a device access
                fresh = (fall_bits | rise_bits) & ~dir_bits;
                if (fresh != 16'h0000) begin
                    if (ok) dir_bits |= fresh;
                    else st = STATUS_FAIL;
                end
            end
            FUNC_SAMPLE: begin
                if (!ok) begin
                    st = STATUS_FAIL;
                end else begin
                    cur  = lv & dir_bits;
                    old  = snap_bits;
                    trig = (cur ^ old) & irq_en_bits;
                    if (trig != 16'h0000) begin
                        snap_bits = cur;
                        pend = ((old & fall_bits) | (cur & rise_bits)) & trig;
                        if (pend != 16'h0000) begin
                            // one result per pending pin, lowest first
                            for (p = 0; p < 16; p++) begin
                                if (pend[p]) begin
                                    pend[p] = 1'b0;
                                    push_result(STATUS_OK, 1'b0, 1'b1, 4'(p), pend == 16'h0000);
                                end
                            end
                            return;
                        end
                    end
                end
            end
            FUNC_LATCH: begin
                if (ok) snap_bits = lv & dir_bits;
                else st = STATUS_FAIL;
            end
            default: ;
        endcase
        push_result(st, rb, 1'b0, 4'd0, 1'b1);
    endfunction

    function automatic t_expander_req make_req(input logic [3:0] func, input logic [3:0] pin,
                                               input logic level, input logic [1:0] edge_type,
                                               input logic [15:0] pin_levels,
                                               input logic bus_fail);
        t_expander_req r;
        r.func       = func;
        r.pin        = pin;
        r.level      = level;
        r.edge_type  = edge_type;
        r.pin_levels = pin_levels;
        r.bus_fail   = bus_fail;
        return r;
    endfunction

    function automatic logic rare_fail();
        return $urandom_range(0, 15) == 0;
    endfunction

    function automatic t_expander_req rand_req();
        t_expander_req r;
        // mostly real operations, now and then an unused code
        if ($urandom_range(0, 7) == 0)
            r.func = 4'($urandom_range(FUNC_LATCH + 1, FUNC_UNUSED_TOP));
        else
            r.func = 4'($urandom_range(FUNC_DIR_IN, FUNC_LATCH));
        r.pin        = 4'($urandom);
        r.level      = 1'($urandom);
        r.edge_type  = 2'($urandom);
        r.pin_levels = 16'($urandom);
        r.bus_fail   = $urandom_range(0, 9) == 0;
        return r;
    endfunction

    // send one item, with an optional random gap in front of it;
    // valid stays high after acceptance so back-to-back items need no drop
    task automatic send_item(input t_expander_req r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_ch.func       <= r.func;
        in_ch.pin        <= r.pin;
        in_ch.level      <= r.level;
        in_ch.edge_type  <= r.edge_type;
        in_ch.pin_levels <= r.pin_levels;
        in_ch.bus_fail   <= r.bus_fail;
        in_ch.valid      <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_results(r);
        items_sent++;
    endtask

    // stop sending and let every owed result come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_access(input logic en);
        cfg_ch.access_enabled <= en;
        cfg_ch.valid          <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        access_en = en;
        access_writes++;
    endtask

    // direction, output level and read-back at the pin extremes, unused code
    task automatic test_register_ops();
        send_item(make_req(FUNC_GET, 4'd0, 1'b0, 2'd0, 16'hFFFF, 1'b0));
        send_item(make_req(FUNC_DIR_OUT, 4'd15, 1'b0, 2'd0, 16'h0000, 1'b0));
        send_item(make_req(FUNC_DIR_OUT, 4'd0, 1'b1, 2'd0, 16'h0000, 1'b0));
        send_item(make_req(FUNC_SET, 4'd15, 1'b1, 2'd3, 16'hFFFF, 1'b0));
        send_item(make_req(FUNC_GET, 4'd15, 1'b1, 2'd0, 16'h8000, 1'b0));
        send_item(make_req(FUNC_DIR_IN, 4'd15, 1'b0, 2'd0, 16'h0000, 1'b0));
        send_item(make_req(FUNC_UNUSED_TOP, 4'd15, 1'b1, 2'd3, 16'hFFFF, 1'b1));
    endtask

    // edge type without any edge, mask and unmask, sync with nothing to do
    task automatic test_edge_type_and_mask();
        send_item(make_req(FUNC_SET_TYPE, 4'd3, 1'b0, 2'd0, 16'h0000, 1'b0));
        send_item(make_req(FUNC_SET_TYPE, 4'd3, 1'b0, 2'd3, 16'h0000, 1'b0));
        send_item(make_req(FUNC_UNMASK, 4'd3, 1'b0, 2'd0, 16'h0000, 1'b0));
        send_item(make_req(FUNC_MASK, 4'd3, 1'b0, 2'd0, 16'h0000, 1'b0));
        send_item(make_req(FUNC_SYNC, 4'd0, 1'b0, 2'd0, 16'h0000, 1'b1));
    endtask

    // device accesses refused while disabled, software ops still work
    task automatic test_access_refused();
        wait_drained();
        write_access(1'b0);
        send_item(make_req(FUNC_SET_TYPE, 4'd0, 1'b0, 2'd1, 16'h0000, 1'b0));
        send_item(make_req(FUNC_UNMASK, 4'd0, 1'b0, 2'd0, 16'h0000, 1'b1));
        send_item(make_req(FUNC_DIR_OUT, 4'd1, 1'b0, 2'd0, 16'h0000, 1'b0));
        send_item(make_req(FUNC_SYNC, 4'd0, 1'b0, 2'd0, 16'h0000, 1'b0));
        send_item(make_req(FUNC_SAMPLE, 4'd0, 1'b0, 2'd0, 16'hFFFF, 1'b0));
        wait_drained();
        write_access(1'b1);
        send_item(make_req(FUNC_LATCH, 4'd0, 1'b0, 2'd0, 16'hFFFF, 1'b1));
        send_item(make_req(FUNC_SYNC, 4'd0, 1'b0, 2'd0, 16'h0000, 1'b0));
    endtask

    // several pending pins in one sample, a quiet sample, a single falling pin
    task automatic test_edge_interrupts();
        send_item(make_req(FUNC_SET_TYPE, 4'd15, 1'b0, 2'd2, 16'h0000, 1'b0));
        send_item(make_req(FUNC_UNMASK, 4'd3, 1'b0, 2'd0, 16'h0000, 1'b0));
        send_item(make_req(FUNC_UNMASK, 4'd15, 1'b0, 2'd0, 16'h0000, 1'b0));
        send_item(make_req(FUNC_LATCH, 4'd0, 1'b0, 2'd0, 16'h8000, 1'b0));
        send_item(make_req(FUNC_SAMPLE, 4'd0, 1'b0, 2'd0, 16'h0009, 1'b0));
        send_item(make_req(FUNC_SAMPLE, 4'd0, 1'b0, 2'd0, 16'h0009, 1'b0));
        send_item(make_req(FUNC_SAMPLE, 4'd0, 1'b0, 2'd0, 16'h0001, 1'b0));
    endtask

    // arm a few pins, latch, then walk the pin levels through several samples
    task automatic irq_burst();
        logic [3:0] p;
        logic [1:0] et;
        p  = 4'd0;
        et = 2'd0;
        repeat ($urandom_range(1, 5)) begin
            p  = 4'($urandom);
            et = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
            send_item(make_req(FUNC_SET_TYPE, p, 1'($urandom), et, 16'($urandom), 1'($urandom)));
            send_item(make_req(FUNC_UNMASK, p, 1'($urandom), 2'($urandom), 16'($urandom),
                               1'($urandom)));
        end
        if ($urandom_range(0, 1))
            send_item(make_req(FUNC_SYNC, 4'($urandom), 1'($urandom), 2'($urandom),
                               16'($urandom), rare_fail()));
        wire_levels = 16'($urandom);
        send_item(make_req(FUNC_LATCH, 4'($urandom), 1'($urandom), 2'($urandom), wire_levels,
                           rare_fail()));
        repeat ($urandom_range(2, 8)) begin
            // mostly a few pins toggle, sometimes all of them move
            if ($urandom_range(0, 3) == 0) wire_levels = 16'($urandom);
            else wire_levels ^= 16'($urandom & $urandom & $urandom);
            if ($urandom_range(0, 5) == 0)
                send_item(make_req(FUNC_MASK, 4'($urandom), 1'($urandom), 2'($urandom),
                                   16'($urandom), 1'($urandom)));
            send_item(make_req(FUNC_SAMPLE, 4'($urandom), 1'($urandom), 2'($urandom),
                               wire_levels, rare_fail()));
        end
    endtask

    // every pin triggered and enabled, then all levels flip both ways
    task automatic arm_all_pins();
        logic [1:0] et;
        bit all_both;
        et = 2'd3;
        all_both = $urandom_range(0, 1);
        for (int p = 0; p < 16; p++) begin
            et = all_both ? 2'd3 : 2'($urandom_range(1, 3));
            send_item(make_req(FUNC_SET_TYPE, 4'(p), 1'($urandom), et, 16'($urandom), 1'b0));
            send_item(make_req(FUNC_UNMASK, 4'(p), 1'($urandom), 2'($urandom), 16'($urandom),
                               1'b0));
        end
        send_item(make_req(FUNC_SYNC, 4'($urandom), 1'b0, 2'($urandom), 16'($urandom), 1'b0));
        send_item(make_req(FUNC_LATCH, 4'($urandom), 1'b0, 2'd0, 16'h0000, 1'b0));
        send_item(make_req(FUNC_SAMPLE, 4'($urandom), 1'b0, 2'd0, 16'hFFFF, 1'b0));
        send_item(make_req(FUNC_LATCH, 4'($urandom), 1'b0, 2'd0, 16'hFFFF, 1'b0));
        send_item(make_req(FUNC_SAMPLE, 4'($urandom), 1'b0, 2'd0, 16'h0000, 1'b0));
        wire_levels = 16'h0000;
    endtask

    // unrelated random items between the interrupt sequences
    task automatic noise_run();
        repeat ($urandom_range(1, 6)) send_item(rand_req());
    endtask

    // one random phase at a fixed access setting, drained now and then
    task automatic test_random_traffic(input int count, input logic en);
        int target;
        int pick;
        target = 0;
        pick   = 0;
        wait_drained();
        write_access(en);
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 9) irq_burst();
            else if (pick == 9) arm_all_pins();
            else noise_run();
            // sender holds off until the block has delivered everything
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
    endtask

    // result side: ready high in stretches, dropped in random bursts
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            if (idle_on && $urandom_range(0, 1)) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end
    end

    // every accepted result against the oldest expectation, field by field
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen_res.status          = out_ch.status;
            seen_res.read_bit        = out_ch.read_bit;
            seen_res.irq_valid       = out_ch.irq_valid;
            seen_res.irq_pin         = out_ch.irq_pin;
            seen_res.last            = out_ch.last;
            seen_res.output_state    = out_ch.output_state;
            seen_res.direction_state = out_ch.direction_state;
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending, irq_pin",
                                16'(seen_res.irq_pin), 16'h0000);
            end else begin
                want_res = expected_results.pop_front();
                if (want_res.irq_valid) irq_results++;
                if (seen_res.status !== want_res.status)
                    report_mismatch("status", 16'(seen_res.status), 16'(want_res.status));
                if (seen_res.read_bit !== want_res.read_bit)
                    report_mismatch("read_bit", 16'(seen_res.read_bit),
                                    16'(want_res.read_bit));
                if (seen_res.irq_valid !== want_res.irq_valid)
                    report_mismatch("irq_valid", 16'(seen_res.irq_valid),
                                    16'(want_res.irq_valid));
                if (seen_res.irq_pin !== want_res.irq_pin)
                    report_mismatch("irq_pin", 16'(seen_res.irq_pin), 16'(want_res.irq_pin));
                if (seen_res.last !== want_res.last)
                    report_mismatch("last", 16'(seen_res.last), 16'(want_res.last));
                if (seen_res.output_state !== want_res.output_state)
                    report_mismatch("output_state", seen_res.output_state,
                                    want_res.output_state);
                if (seen_res.direction_state !== want_res.direction_state)
                    report_mismatch("direction_state", seen_res.direction_state,
                                    want_res.direction_state);
            end
        end
    end

    // main sequence
    initial begin
        in_ch.valid           <= 1'b0;
        in_ch.func            <= FUNC_DIR_IN;
        in_ch.pin             <= 4'd0;
        in_ch.level           <= 1'b0;
        in_ch.edge_type       <= 2'd0;
        in_ch.pin_levels      <= 16'h0000;
        in_ch.bus_fail        <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.access_enabled <= 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        test_register_ops();
        test_edge_type_and_mask();
        test_access_refused();
        test_edge_interrupts();

        // random part across both access settings
        test_random_traffic(180, 1'b1);
        test_random_traffic(50, 1'b0);
        test_random_traffic(100, 1'b1);

        // closing stretch at full rate on both sides
        idle_on <= 1'b0;
        test_random_traffic(90, 1'b1);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered, count", 16'(expected_results.size()),
                            16'h0000);

        $display("ran %0d items through %0d access writes, %0d results checked",
                 items_sent, access_writes, results_seen);
        $display("%0d of the results were interrupt pins, %0d mismatches",
                 irq_results, err_count);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
